FILE: src/sta_pkg.sv
`default_nettype none

package sta_pkg;

   // Activation format: signed, DATA_WIDTH bits, FRAC_BITS fraction bits
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 10;

   // Result format: unsigned Q0.16
   localparam int OUT_W   = 16;
   localparam int SLOPE_W = 15;

   // Quotient Q = floor(2^NUM_EXP / D), D >= 2^(2*FRAC_BITS+2), so Q <= 2^15
   localparam int NUM_EXP = 2 * FRAC_BITS + 17;
   localparam int QUO_W   = 16;

   // Divisor D = 2^(2F+2) + 2^(F+1)*A + A*A, A < 2^DATA_WIDTH
   localparam int DIV_W = (2 * DATA_WIDTH > 2 * FRAC_BITS + 4) ?
                          2 * DATA_WIDTH : 2 * FRAC_BITS + 4;
   localparam int SQ_W  = 2 * DATA_WIDTH;

   localparam logic [DIV_W-1:0] D_BASE   = DIV_W'(1) << (2 * FRAC_BITS + 2);
   localparam logic [DIV_W-1:0] REM_INIT = DIV_W'(1) << (NUM_EXP - QUO_W);

   localparam logic [OUT_W:0]   ONE_Q16 = (OUT_W + 1)'(1) << OUT_W;
   localparam logic [OUT_W-1:0] SAT_Q16 = '1;

   // 1 magnitude + 1 square + 1 divisor + QUO_W divide + 1 sigmoid + 1 slope
   localparam int LATENCY = QUO_W + 5;

endpackage

`default_nettype wire

FILE: src/sigmoid_taylor_approx.sv
// Sigmoid activation with slope, from a truncated exponential series.
// Input channel (req_): one signed Q5.10 activation per transfer in
// req_x_value. Result channel (rsp_): rsp_sigmoid_value (unsigned Q0.16,
// 1.0 saturates to 65535) and rsp_slope_value = s*(1-s) in Q0.16.
// Exactly one result per input item, in input order.
// The path from input transfer to rsp_valid runs through the chain of
// one magnitude stage, one squaring stage, one divisor stage, sixteen
// restoring-division stages (one quotient bit each), one sigmoid stage
// and one slope-multiply stage, whose last register drives the rsp_ ports.
// Throughput: one item per cycle while the receiver takes results.
// The pipeline advances as a whole whenever the output register is empty
// or its result is transferred; when the receiver stalls with a result
// waiting, every stage holds and req_ready drops, so no item is lost or
// repeated. Bubbles travel as cleared valid bits.
// Reset (synchronous, active high) clears all valid bits; the block keeps
// no state between items and is ready in the cycle after reset.

`default_nettype none

module sigmoid_taylor_approx
   import sta_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [OUT_W-1:0]                rsp_sigmoid_value,
   output logic [SLOPE_W-1:0]              rsp_slope_value
);

   // Advance every stage when the output slot is free or being drained
   logic adv;
   logic out_vld_ff;

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage A: magnitude and sign ----------------
   logic                  a_vld_ff;
   logic [DATA_WIDTH-1:0] a_mag_ff;
   logic                  a_pos_ff;
   logic [DATA_WIDTH-1:0] a_mag_in;
   logic                  a_pos_in;
   logic [DATA_WIDTH-1:0] x_raw;

   always_comb begin
      x_raw    = req_x_value;
      // most negative value keeps its magnitude 2^(DATA_WIDTH-1) as unsigned
      a_mag_in = x_raw[DATA_WIDTH-1] ? (~x_raw + DATA_WIDTH'(1)) : x_raw;
      a_pos_in = !x_raw[DATA_WIDTH-1] && (x_raw != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= a_mag_in;
         a_pos_ff <= a_pos_in;
      end
   end

   // ---------------- stage B: square ----------------
   logic                  b_vld_ff;
   logic [DATA_WIDTH-1:0] b_mag_ff;
   logic [SQ_W-1:0]       b_sq_ff;
   logic                  b_pos_ff;
   logic [SQ_W-1:0]       b_sq_in;

   assign b_sq_in = SQ_W'(a_mag_ff) * SQ_W'(a_mag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_mag_ff <= a_mag_ff;
         b_sq_ff  <= b_sq_in;
         b_pos_ff <= a_pos_ff;
      end
   end

   // ---------------- stage C: divisor ----------------
   // D = 2^22 + 2^11*A + A*A; the division stages hang off index 0
   logic [DIV_W-1:0] dv_d_ff [0:QUO_W];
   logic [DIV_W-1:0] dv_r_ff [0:QUO_W];
   logic [QUO_W-1:0] dv_q_ff [0:QUO_W];
   logic             dv_p_ff [0:QUO_W];
   logic             dv_v_ff [0:QUO_W];
   logic [DIV_W-1:0] c_d_in;

   assign c_d_in = D_BASE + (DIV_W'(b_mag_ff) << (FRAC_BITS + 1)) + DIV_W'(b_sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_d_ff[0] <= c_d_in;
         dv_r_ff[0] <= REM_INIT;
         dv_q_ff[0] <= '0;
         dv_p_ff[0] <= b_pos_ff;
      end
   end

   // ---------------- division stages: one quotient bit each ----------------
   // Restoring division of 2^37 by D; the remainder stays below D, and the
   // low numerator bits are all zero, so each step shifts in a zero.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      logic [DIV_W:0]   trial;
      logic             take;
      logic [DIV_W-1:0] r_in;
      logic [QUO_W-1:0] q_in;

      always_comb begin
         trial = {dv_r_ff[k-1], 1'b0};
         take  = trial >= {1'b0, dv_d_ff[k-1]};
         r_in  = take ? DIV_W'(trial - {1'b0, dv_d_ff[k-1]}) : DIV_W'(trial);
         q_in  = {dv_q_ff[k-1][QUO_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_d_ff[k] <= dv_d_ff[k-1];
            dv_r_ff[k] <= r_in;
            dv_q_ff[k] <= q_in;
            dv_p_ff[k] <= dv_p_ff[k-1];
         end
      end
   end

   // ---------------- stage E: sigmoid ----------------
   // positive x: 1 - 1/(1+E), i.e. one minus the exact quotient, rounded up
   logic             e_vld_ff;
   logic [OUT_W-1:0] e_sig_ff;
   logic [OUT_W-1:0] e_sig_in;
   logic [OUT_W:0]   e_diff;
   logic [OUT_W:0]   e_quo;

   always_comb begin
      e_quo  = (OUT_W + 1)'(dv_q_ff[QUO_W]);
      e_diff = ONE_Q16 - e_quo;
      if (dv_p_ff[QUO_W]) begin
         e_sig_in = e_diff[OUT_W] ? SAT_Q16 : e_diff[OUT_W-1:0];
      end else begin
         e_sig_in = e_quo[OUT_W] ? SAT_Q16 : e_quo[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= dv_v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_sig_ff <= e_sig_in;
      end
   end

   // ---------------- stage F: slope, output register ----------------
   logic [OUT_W-1:0]   out_sig_ff;
   logic [SLOPE_W-1:0] out_slope_ff;
   logic [OUT_W:0]     f_comp;
   logic [2*OUT_W:0]   f_prod;
   logic [SLOPE_W-1:0] f_slope_in;

   always_comb begin
      f_comp     = ONE_Q16 - (OUT_W + 1)'(e_sig_ff);
      f_prod     = (2 * OUT_W + 1)'(e_sig_ff) * (2 * OUT_W + 1)'(f_comp);
      f_slope_in = f_prod[OUT_W + SLOPE_W - 1:OUT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_sig_ff   <= e_sig_ff;
         out_slope_ff <= f_slope_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_sigmoid_value = out_sig_ff;
   assign rsp_slope_value   = out_slope_ff;

endmodule

`default_nettype wire
